// File: src/bd_pkg.sv
package bd_pkg;

	// Entries in the queue between the decode front and the result back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] STATUS_RUNNING = 2'd0;
	localparam logic [1:0] STATUS_OK      = 2'd1;
	localparam logic [1:0] STATUS_ERROR   = 2'd2;

	// One queue entry: everything one input character leaves for the back end
	typedef struct packed {
		logic [2:0][7:0] bytes;   // bytes[0] goes out first
		logic [1:0]      nbytes;  // 0..3 decoded bytes
		logic            eoi;     // text ends with this entry
		logic            err;     // invalid character seen in this text
	} entry_t;

	// Alphabet lookup: {valid, sextet}
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		logic       ok;
		v  = 8'd0;
		ok = 1'b1;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 8'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 8'(c - 8'h47);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 8'(c + 8'h04);
		end else if (c == 8'h2B) begin
			v = 8'd62;
		end else if (c == 8'h2F) begin
			v = 8'd63;
		end else begin
			ok = 1'b0;
		end
		return {ok, v[5:0]};
	endfunction

endpackage

// File: src/bd_front.sv
module bd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_code,
	input  logic           end_of_input,
	output logic           entry_push,
	output bd_pkg::entry_t entry
);
	import bd_pkg::*;

	logic [7:0] held_q [3];
	logic [1:0] pos_q;
	logic       fin_q;
	logic       err_q;

	logic       active;
	logic [7:0] q [4];
	logic [5:0] s [4];
	logic [3:0] is_pad;
	logic [3:0] is_ok;
	logic [6:0] lk [4];
	logic [1:0] n;
	logic       new_fin;
	logic       new_err;
	logic       decode;

	assign active = !fin_q && !err_q;
	assign decode = active && (pos_q == 2'd3);

	always_comb begin
		q[0] = held_q[0];
		q[1] = held_q[1];
		q[2] = held_q[2];
		q[3] = char_code;
		for (int i = 0; i < 4; i++) begin
			lk[i]     = sextet_of(q[i]);
			s[i]      = lk[i][5:0];
			is_ok[i]  = lk[i][6];
			is_pad[i] = (q[i] == PAD_CHAR);
		end
	end

	// Left to right: a pad or bad character stops the quartet at its place
	always_comb begin
		n       = 2'd0;
		new_fin = 1'b0;
		new_err = 1'b0;
		if (is_pad[0]) begin
			new_fin = 1'b1;
		end else if (!is_ok[0]) begin
			new_err = 1'b1;
		end else if (is_pad[1]) begin
			new_fin = 1'b1;
		end else if (!is_ok[1]) begin
			new_err = 1'b1;
		end else if (is_pad[2]) begin
			new_fin = 1'b1;
			n       = 2'd1;
		end else if (!is_ok[2]) begin
			new_err = 1'b1;
			n       = 2'd1;
		end else if (is_pad[3]) begin
			new_fin = 1'b1;
			n       = 2'd2;
		end else if (!is_ok[3]) begin
			new_err = 1'b1;
			n       = 2'd2;
		end else begin
			n = 2'd3;
		end
	end

	always_comb begin
		entry.bytes[0] = {s[0], s[1][5:4]};
		entry.bytes[1] = {s[1][3:0], s[2][5:2]};
		entry.bytes[2] = {s[2][1:0], s[3]};
		entry.nbytes   = decode ? n : 2'd0;
		entry.eoi      = end_of_input;
		entry.err      = err_q || (decode && new_err);
		entry_push     = accept && (end_of_input || (entry.nbytes != 2'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			fin_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (end_of_input) begin
				pos_q <= 2'd0;
				fin_q <= 1'b0;
				err_q <= 1'b0;
			end else if (decode) begin
				pos_q <= 2'd0;
				fin_q <= new_fin;
				err_q <= new_err;
			end else if (active) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active && (pos_q != 2'd3)) begin
			held_q[pos_q] <= char_code;
		end
	end

endmodule

// File: src/bd_queue.sv
module bd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  bd_pkg::entry_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output bd_pkg::entry_t rd_data,
	output logic           not_empty
);
	import bd_pkg::*;

	entry_t              store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data   = store_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: src/bd_back.sv
module bd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bd_pkg::entry_t head,
	input  logic           head_valid,
	output logic           head_done,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     data_byte,
	output logic           has_byte,
	output logic [1:0]     status,
	output logic           last
);
	import bd_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       last_slot;
	logic       take;

	// An entry with no bytes still gives one result (the final one)
	assign last_idx  = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
	assign last_slot = (idx_q == last_idx);
	assign take      = pop && head_valid;
	assign head_done = take && last_slot;
	assign empty     = !head_valid;

	always_comb begin
		has_byte  = (head.nbytes != 2'd0);
		data_byte = has_byte ? head.bytes[idx_q] : 8'd0;
		last      = head.eoi && last_slot;
		if (!last) begin
			status = STATUS_RUNNING;
		end else if (head.err) begin
			status = STATUS_ERROR;
		end else begin
			status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= last_slot ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: src/base64_stream_decoder_core.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           char_code[7:0], end_of_input
// result    out        empty / pop           data_byte[7:0], has_byte, status[1:0], last
//
// Takes one character per cycle while full is low; full rises only when the 4-entry
// queue is full. A character gives 0..3 results; they leave one per cycle while pop
// is high. A quartet's bytes share one queue entry, so a full quartet costs at most
// three pops over four transfers, and an end of input that closes no quartet costs
// one pop of its own. A transfer's results show once its entry heads the queue.
// arst_n clears the quartet position, the pad/error flags and the queue.
// A stalled result side backs up only through the queue into full.
module base64_stream_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       has_byte,
	output logic [1:0] status,
	output logic       last
);
	import bd_pkg::*;

	logic   accept;
	logic   entry_push;
	entry_t entry;
	entry_t head;
	logic   head_valid;
	logic   head_done;

	// input transfer
	assign accept = push && !full;

	// front: quartet assembly, alphabet lookup, pad/error tracking
	bd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.entry_push   (entry_push),
		.entry        (entry)
	);

	// decouples the decode side from the result side
	bd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (entry_push),
		.wr_data   (entry),
		.full      (full),
		.rd_en     (head_done),
		.rd_data   (head),
		.not_empty (head_valid)
	);

	// back: walks the head entry one result per transfer
	bd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_done  (head_done),
		.empty      (empty),
		.pop        (pop),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.status     (status),
		.last       (last)
	);

`ifndef SYNTH
	// status is given on the final result and nowhere else
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (status != STATUS_RUNNING)))
		else $error("status and last disagree");

	// a result without a byte only ever closes a text
	a_nobyte_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_byte) |-> last)
		else $error("byte-less result that is not final");

	// results only drain through a pop
	a_empty_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result queue drained without a pop");
`endif

endmodule

// File: dv/tb_base64_stream_decoder_core.sv
module tb_base64_stream_decoder_core;
	import bd_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 300000;   // far above the slowest legal run
	localparam int DRAIN_CYCLES = 24;       // queue depth plus margin for late extras
	localparam int TEXT_QUOTA   = 112;      // minimum characters sent per idle phase

	// One result as it should appear on the result ports
	typedef struct {
		logic [7:0] data_byte;
		logic       has_byte;
		logic [1:0] status;
		logic       last;
	} decoded_out_t;

	// Tracks quartet assembly and the stop conditions, and keeps the
	// results still owed by the core in arrival order.
	class decode_tracker;
		logic [7:0]   held [3];
		logic [1:0]   fill;
		bit           pad_hit;
		bit           bad_hit;
		decoded_out_t awaited [$];
		int           error_count;

		function new();
			error_count = 0;
			restart();
		endfunction

		function void restart();
			held    = '{default: 8'd0};
			fill    = 2'd0;
			pad_hit = 1'b0;
			bad_hit = 1'b0;
		endfunction

		// Standard alphabet with '+' and '/'; returns 0 for anything else
		static function bit to_sextet(input logic [7:0] c, output logic [5:0] v);
			bit ok;
			ok = 1'b1;
			v  = 6'd0;
			if (c >= 8'h41 && c <= 8'h5A)
				v = 6'(c - 8'h41);
			else if (c >= 8'h61 && c <= 8'h7A)
				v = 6'(c - 8'h61 + 8'd26);
			else if (c >= 8'h30 && c <= 8'h39)
				v = 6'(c - 8'h30 + 8'd52);
			else if (c == 8'h2B)
				v = 6'd62;
			else if (c == 8'h2F)
				v = 6'd63;
			else
				ok = 1'b0;
			return ok;
		endfunction

		// Called on every input transfer; returns 1 unless the character was
		// swallowed by the post-stop ignore state.
		function bit note_char(input logic [7:0] c, input logic eoi);
			logic [7:0]   quad [4];
			logic [5:0]   sx [4];
			decoded_out_t step_q [$];
			decoded_out_t r;
			bit           live;
			live = !pad_hit && !bad_hit;
			sx   = '{default: 6'd0};
			if (live) begin
				if (fill != 2'd3) begin
					held[fill] = c;
					fill = fill + 2'd1;
				end else begin
					quad = '{held[0], held[1], held[2], c};
					fill = 2'd0;
					// Left to right: a pad stops cleanly, a bad character stops
					// with error; bytes finished before the stop still go out.
					for (int i = 0; i < 4; i++) begin
						if (quad[i] == PAD_CHAR) begin
							pad_hit = 1'b1;
							break;
						end
						if (!to_sextet(quad[i], sx[i])) begin
							bad_hit = 1'b1;
							break;
						end
						if (i > 0) begin
							r = '{data_byte: 8'd0, has_byte: 1'b1,
								status: STATUS_RUNNING, last: 1'b0};
							case (i)
								1: begin
									r.data_byte = {sx[0], sx[1][5:4]};
								end
								2: begin
									r.data_byte = {sx[1][3:0], sx[2][5:2]};
								end
								default: begin
									r.data_byte = {sx[2][1:0], sx[3]};
								end
							endcase
							step_q.push_back(r);
						end
					end
				end
			end
			// End of text: status rides on the last byte, or on an empty result.
			// Any partial quartet is simply dropped.
			if (eoi) begin
				if (step_q.size() == 0)
					step_q.push_back('{8'd0, 1'b0, STATUS_RUNNING, 1'b0});
				r = step_q.pop_back();
				r.status = bad_hit ? STATUS_ERROR : STATUS_OK;
				r.last   = 1'b1;
				step_q.push_back(r);
				restart();
			end
			foreach (step_q[k])
				awaited.push_back(step_q[k]);
			return live || eoi;
		endfunction

		function void check_result(input logic [7:0] d, input logic hb,
			input logic [1:0] st, input logic lst);
			decoded_out_t e;
			if (awaited.size() == 0) begin
				error_count++;
				$error("unexpected result: data_byte %h has_byte %b status %0d last %b",
					d, hb, st, lst);
				return;
			end
			e = awaited.pop_front();
			if (d !== e.data_byte) begin
				error_count++;
				$error("data_byte: expected %h, got %h", e.data_byte, d);
			end
			if (hb !== e.has_byte) begin
				error_count++;
				$error("has_byte: expected %b, got %b", e.has_byte, hb);
			end
			if (st !== e.status) begin
				error_count++;
				$error("status: expected %0d, got %0d", e.status, st);
			end
			if (lst !== e.last) begin
				error_count++;
				$error("last: expected %b, got %b", e.last, lst);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_code;
	logic       end_of_input;
	logic       empty;
	logic       pop;
	logic [7:0] data_byte;
	logic       has_byte;
	logic [1:0] status;
	logic       last;

	decode_tracker tracker;
	logic [7:0]    text_buf [$];    // characters of the text about to be sent
	int            send_idle_pct;   // chance of a gap before each push transfer
	int            recv_idle_pct;   // chance of pop held low in a cycle
	int            sent_chars;      // input transfers so far
	int unsigned   cycles;

	base64_stream_decoder_core uut (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Watchdog: a hung handshake or lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		if (v < 6'd26)
			return 8'h41 + 8'(v);
		else if (v < 6'd52)
			return 8'h61 + 8'(v - 6'd26);
		else if (v < 6'd62)
			return 8'h30 + 8'(v - 6'd52);
		else if (v == 6'd62)
			return 8'h2B;
		return 8'h2F;
	endfunction

	// One push transfer. push is left high on return so back-to-back
	// characters keep it asserted; the next call or the caller lowers it.
	task automatic send_char(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		@(posedge clk);
		while (full)
			@(posedge clk);
		void'(tracker.note_char(c, eoi));
		sent_chars++;
	endtask

	// Sends text_buf with end_of_input on its last character, then empties it
	task automatic send_text();
		foreach (text_buf[i])
			send_char(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	task automatic append_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s.getc(i));
	endtask

	// Half are proper encodings of random bytes; the rest are unpadded
	// texts, junk after the end, a corrupted character, or raw noise.
	task automatic build_random_text();
		int          kind;
		int          nbytes;
		int          left;
		logic [23:0] grp;
		kind = $urandom_range(99);
		text_buf.delete();
		if (kind >= 90) begin
			repeat ($urandom_range(1, 9))
				text_buf.push_back(8'($urandom_range(255)));
			return;
		end
		nbytes = $urandom_range(0, 7);
		for (int i = 0; i < nbytes; i += 3) begin
			left = nbytes - i;
			grp = {8'($urandom_range(255)),
				left > 1 ? 8'($urandom_range(255)) : 8'd0,
				left > 2 ? 8'($urandom_range(255)) : 8'd0};
			text_buf.push_back(sextet_char(grp[23:18]));
			text_buf.push_back(sextet_char(grp[17:12]));
			text_buf.push_back(left > 1 ? sextet_char(grp[11:6]) : PAD_CHAR);
			text_buf.push_back(left > 2 ? sextet_char(grp[5:0]) : PAD_CHAR);
		end
		// Unpadded form: the short tail becomes a dropped partial quartet
		if (kind >= 50 && kind < 65) begin
			while (text_buf.size() > 0 && text_buf[$] == PAD_CHAR)
				void'(text_buf.pop_back());
		end
		if (text_buf.size() == 0)
			text_buf.push_back(sextet_char(6'($urandom_range(63))));
		// Trailing junk: ignored after a pad, decoded otherwise
		if (kind >= 65 && kind < 80) begin
			repeat ($urandom_range(1, 4))
				text_buf.push_back(8'($urandom_range(255)));
		end
		// One character overwritten by an arbitrary byte
		if (kind >= 80)
			text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
	endtask

	task automatic run_texts(input int quota);
		int start;
		start = sent_chars;
		while (sent_chars - start < quota) begin
			build_random_text();
			send_text();
		end
	endtask

	// Result side: pop is redrawn every cycle, a transfer is checked at once
	task automatic take_results();
		forever begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
			@(posedge clk);
			if (pop && !empty)
				tracker.check_result(data_byte, has_byte, status, last);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		char_code    = 8'd0;
		end_of_input = 1'b0;
		cycles       = 0;
		sent_chars   = 0;
		tracker      = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 73;
		fork
			take_results();
		join_none

		// Directed texts
		append_str("+/9z");                 // plus, slash, digit, lower case
		send_text();
		append_str("Zm8=");                 // pad in fourth place: two bytes
		text_buf.push_back(8'hFF);          // ignored after the pad, ends text
		send_text();
		append_str("TQ==");                 // pad in third place: one byte
		send_text();
		append_str("T=");                   // pad in second place: no byte
		text_buf.push_back(8'h00);
		append_str("A");
		send_text();
		append_str("=QQQ");                 // pad in first place
		send_text();
		append_str("Tw");                   // bad character in third place:
		text_buf.push_back(8'hFF);          // one byte out, then error status
		append_str("ux");
		send_text();
		append_str("A");                    // lone partial quartet
		send_text();

		// Random texts under three idle mixes
		run_texts(TEXT_QUOTA);
		send_idle_pct = 73;
		recv_idle_pct = 34;
		run_texts(TEXT_QUOTA);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_texts(TEXT_QUOTA);
		push <= 1'b0;

		// Drain, then linger to catch anything extra the core emits
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
